// ===== hw/rtl/sscq_pkg.sv =====
// ----------------------------------------------------------------------------
// sscq_pkg
// Types, opcodes and event codes shared by the command queue files.
// ----------------------------------------------------------------------------
package sscq_pkg;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_BACK    = 3'd1;
	localparam logic [2:0] OP_FRONT   = 3'd2;
	localparam logic [2:0] OP_SUCCESS = 3'd3;
	localparam logic [2:0] OP_FAIL    = 3'd4;
	localparam logic [2:0] OP_FORGET  = 3'd5;
	localparam logic [2:0] OP_DISCARD = 3'd6;
	localparam logic [2:0] OP_COUNT   = 3'd7;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_ISSUE   = 3'd1;
	localparam logic [2:0] EV_ABANDON = 3'd2;
	localparam logic [2:0] EV_COUNT   = 3'd3;
	localparam logic [2:0] EV_FULL    = 3'd4;

	localparam int IDENT_W  = 40;
	localparam int POLICY_W = 36;
	localparam int ENTRY_W  = IDENT_W + POLICY_W;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  requester_id;
		logic [15:0] key_handle;
		logic [15:0] command_tag;
		logic [15:0] pace_ticks;
		logic [3:0]  retry_limit;
		logic [15:0] retry_delay_ticks;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  event_requester;
		logic [15:0] event_key;
		logic [15:0] event_tag;
		logic [6:0]  dropped_or_pending;
		logic [6:0]  queued_total;
		logic        slot_busy;
		logic [7:0]  slot_requester;
		logic        depth_warning;
	} evt_t;

	// ident: requester, key, tag; policy: pace, limit, delay
	function automatic logic [IDENT_W-1:0] make_ident(input cmd_t c);
		return {c.requester_id, c.key_handle, c.command_tag};
	endfunction

	function automatic logic [POLICY_W-1:0] make_policy(input cmd_t c);
		return {c.pace_ticks, c.retry_limit, c.retry_delay_ticks};
	endfunction

endpackage

// ===== hw/rtl/sscq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sscq_cmd_if
// Request channel carrying one command.
// ----------------------------------------------------------------------------
interface sscq_cmd_if;
	logic           valid;
	logic           ready;
	sscq_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sscq_evt_if.sv =====
// ----------------------------------------------------------------------------
// sscq_evt_if
// Result channel carrying one event request.
// ----------------------------------------------------------------------------
interface sscq_evt_if;
	logic           valid;
	logic           ready;
	sscq_pkg::evt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sscq_ram.sv =====
// ----------------------------------------------------------------------------
// sscq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sscq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/single_slot_command_queue_retry_core.sv =====
// ----------------------------------------------------------------------------
// single_slot_command_queue_retry_core
// Bounded command queue feeding a single outstanding slot with retry timing.
// ----------------------------------------------------------------------------
// Tick, submit, success and failure: accepted in IDLE, worked in EXEC and
// loaded into the output register in EMIT once that register is free.
// Forget, discard and count walk the queue RAM in WALK, one entry a cycle,
// then settle in FIN before EMIT. One command is worked at a time; the next is
// taken while the previous result still waits on the output register.
// Reset clears the queue pointers, slot and timers; RAM content is not reset.
module single_slot_command_queue_retry_core #(
	parameter int QUEUE_DEPTH = 64,
	parameter int WARN_DEPTH  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sscq_cmd_if.sink   cmd,
	sscq_evt_if.source evt
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                    st_q;
	sscq_pkg::cmd_t                cmd_q;
	logic                          owner_q;
	logic [AW-1:0]                 head_q;
	logic [CW-1:0]                 qc_q;
	logic                          slot_valid_q;
	logic [sscq_pkg::IDENT_W-1:0]  slot_ident_q;
	logic [sscq_pkg::POLICY_W-1:0] slot_policy_q;
	logic [3:0]                    retries_q;
	logic                          d_armed_q;
	logic [15:0]                   d_rem_q;
	logic                          r_armed_q;
	logic [15:0]                   r_rem_q;
	logic                          warn_latched_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 wr_q;
	logic [CW-1:0]                 cnt_q;
	logic [2:0]                    res_kind_q;
	logic [sscq_pkg::IDENT_W-1:0]  res_ev_q;
	logic [6:0]                    res_count_q;
	logic                          res_warn_q;
	logic                          ov_q;
	sscq_pkg::evt_t                evt_q;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// RAM
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [sscq_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [sscq_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [sscq_pkg::IDENT_W-1:0]  rd_ident;
	logic [sscq_pkg::POLICY_W-1:0] rd_policy;

	sscq_ram #(.WIDTH(sscq_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ident  = ram_rdata[sscq_pkg::ENTRY_W-1:sscq_pkg::POLICY_W];
	assign rd_policy = ram_rdata[sscq_pkg::POLICY_W-1:0];

	// combinational helpers
	logic          q_full;
	logic          is_submit;
	logic [AW-1:0] head_prev;
	logic [AW-1:0] sub_pos;
	logic [CW-1:0] qc_inc;
	logic [15:0]   r_next_rem;
	logic [15:0]   d_next_rem;
	logic          r_fire;
	logic          d_fire;
	logic          tick_retry;
	logic          tick_disp;
	logic          walk_match;
	logic          walk_purge;
	logic          walk_last;
	logic [31:0]   fin_cnt32;
	logic [31:0]   qc32;
	logic          fin_sv;
	logic          fin_da;

	assign q_full    = 32'(qc_q) >= 32'(QUEUE_DEPTH);
	assign is_submit = (cmd_q.opcode == sscq_pkg::OP_BACK) ||
		(cmd_q.opcode == sscq_pkg::OP_FRONT);
	assign head_prev = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - 1'b1;
	assign sub_pos   = (cmd_q.opcode == sscq_pkg::OP_BACK) ? ring_add(head_q, qc_q)
		: head_prev;
	assign qc_inc    = qc_q + 1'b1;

	assign r_next_rem = (r_rem_q != 16'd0) ? r_rem_q - 16'd1 : 16'd0;
	assign d_next_rem = (d_rem_q != 16'd0) ? d_rem_q - 16'd1 : 16'd0;
	assign r_fire     = r_armed_q && (r_next_rem == 16'd0);
	assign d_fire     = d_armed_q && (d_next_rem == 16'd0);
	assign tick_retry = r_fire && slot_valid_q;
	assign tick_disp  = d_fire && !tick_retry && !slot_valid_q && (qc_q != '0);

	assign walk_match = (rd_ident[39:32] == cmd_q.requester_id) &&
		((cmd_q.opcode != sscq_pkg::OP_DISCARD) || (rd_ident[31:16] == cmd_q.key_handle));
	assign walk_purge = cmd_q.opcode != sscq_pkg::OP_COUNT;
	assign walk_last  = (idx_q + 1'b1) == qc_q;

	assign fin_cnt32 = 32'(cnt_q) +
		(((cmd_q.opcode == sscq_pkg::OP_FORGET) && owner_q) ? 32'd1 : 32'd0);
	assign qc32      = 32'(qc_q);
	// slot and dispatch arm after a forget
	assign fin_sv = slot_valid_q && !((cmd_q.opcode == sscq_pkg::OP_FORGET) && owner_q);
	assign fin_da = d_armed_q && !((cmd_q.opcode == sscq_pkg::OP_FORGET) && owner_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sub_pos;
		ram_wdata = {sscq_pkg::make_ident(cmd_q), sscq_pkg::make_policy(cmd_q)};
		ram_raddr = head_q;
		if (st_q == ST_EXEC) begin
			ram_we = is_submit && !q_full;
		end
		if (st_q == ST_WALK) begin
			// kept entries close up behind the read pointer
			ram_we    = walk_purge && !walk_match;
			ram_waddr = ring_add(head_q, wr_q);
			ram_wdata = ram_rdata;
			ram_raddr = ring_add(head_q, idx_q + 1'b1);
		end
	end

	assign cmd.ready = st_q == ST_IDLE;
	assign evt.valid = ov_q;
	assign evt.data  = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			owner_q        <= 1'b0;
			head_q         <= '0;
			qc_q           <= '0;
			slot_valid_q   <= 1'b0;
			slot_ident_q   <= '0;
			slot_policy_q  <= '0;
			retries_q      <= '0;
			d_armed_q      <= 1'b0;
			d_rem_q        <= '0;
			r_armed_q      <= 1'b0;
			r_rem_q        <= '0;
			warn_latched_q <= 1'b0;
			idx_q          <= '0;
			wr_q           <= '0;
			cnt_q          <= '0;
			ov_q           <= 1'b0;
		end else begin
			if (ov_q && evt.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd.data;
						owner_q <= slot_valid_q &&
							(slot_ident_q[39:32] == cmd.data.requester_id);
						st_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_kind_q  <= sscq_pkg::EV_NONE;
					res_ev_q    <= '0;
					res_count_q <= '0;
					res_warn_q  <= 1'b0;
					st_q        <= ST_EMIT;
					unique case (cmd_q.opcode)
						sscq_pkg::OP_TICK: begin
							if (r_armed_q) begin
								r_rem_q <= r_next_rem;
								if (r_fire) r_armed_q <= 1'b0;
							end
							if (d_armed_q) begin
								d_rem_q <= d_next_rem;
								if (d_fire) d_armed_q <= 1'b0;
							end
							if (tick_retry) begin
								res_kind_q <= sscq_pkg::EV_ISSUE;
								res_ev_q   <= slot_ident_q;
							end else if (tick_disp) begin
								slot_valid_q  <= 1'b1;
								slot_ident_q  <= rd_ident;
								slot_policy_q <= rd_policy;
								retries_q     <= '0;
								r_armed_q     <= 1'b0;
								r_rem_q       <= '0;
								head_q        <= ring_add(head_q, CW'(1));
								qc_q          <= qc_q - 1'b1;
								res_kind_q    <= sscq_pkg::EV_ISSUE;
								res_ev_q      <= rd_ident;
							end
						end
						sscq_pkg::OP_BACK, sscq_pkg::OP_FRONT: begin
							if (q_full) begin
								res_kind_q <= sscq_pkg::EV_FULL;
								res_ev_q   <= sscq_pkg::make_ident(cmd_q);
							end else begin
								if (cmd_q.opcode == sscq_pkg::OP_FRONT) head_q <= head_prev;
								qc_q <= qc_inc;
								// hysteresis: set at WARN_DEPTH, clear at half
								if (32'(qc_inc) >= 32'(WARN_DEPTH)) begin
									if (!warn_latched_q) begin
										warn_latched_q <= 1'b1;
										res_warn_q     <= 1'b1;
									end
								end else if (32'(qc_inc) <= 32'(WARN_DEPTH / 2)) begin
									warn_latched_q <= 1'b0;
								end
								if (!slot_valid_q && !d_armed_q) begin
									d_armed_q <= 1'b1;
									d_rem_q   <= '0;
								end
							end
						end
						sscq_pkg::OP_SUCCESS: begin
							if (owner_q) begin
								slot_valid_q  <= 1'b0;
								slot_ident_q  <= '0;
								slot_policy_q <= '0;
								retries_q     <= '0;
								r_armed_q     <= 1'b0;
								r_rem_q       <= '0;
								if (slot_policy_q[35:20] != 16'd0 && qc_q != '0) begin
									d_armed_q <= 1'b1;
									d_rem_q   <= slot_policy_q[35:20];
								end else if (!d_armed_q && qc_q != '0) begin
									d_armed_q <= 1'b1;
									d_rem_q   <= '0;
								end
							end
						end
						sscq_pkg::OP_FAIL: begin
							if (owner_q) begin
								if (retries_q < slot_policy_q[19:16]) begin
									retries_q <= retries_q + 4'd1;
									r_armed_q <= 1'b1;
									r_rem_q   <= slot_policy_q[15:0];
								end else begin
									res_kind_q    <= sscq_pkg::EV_ABANDON;
									res_ev_q      <= slot_ident_q;
									slot_valid_q  <= 1'b0;
									slot_ident_q  <= '0;
									slot_policy_q <= '0;
									retries_q     <= '0;
									r_armed_q     <= 1'b0;
									r_rem_q       <= '0;
									d_armed_q     <= qc_q != '0;
									d_rem_q       <= '0;
								end
							end
						end
						default: begin
							// forget, discard, count: walk from the head
							idx_q <= '0;
							wr_q  <= '0;
							cnt_q <= '0;
							st_q  <= (qc_q == '0) ? ST_FIN : ST_WALK;
						end
					endcase
				end
				ST_WALK: begin
					if (walk_match) cnt_q <= cnt_q + 1'b1;
					else wr_q <= wr_q + 1'b1;
					if (walk_last) st_q <= ST_FIN;
					else idx_q <= idx_q + 1'b1;
				end
				ST_FIN: begin
					res_ev_q    <= '0;
					res_warn_q  <= 1'b0;
					res_count_q <= fin_cnt32[6:0];
					res_kind_q  <= (cmd_q.opcode == sscq_pkg::OP_COUNT) ? sscq_pkg::EV_COUNT
						: sscq_pkg::EV_NONE;
					if (cmd_q.opcode != sscq_pkg::OP_COUNT) qc_q <= wr_q;
					if (cmd_q.opcode == sscq_pkg::OP_FORGET) begin
						if (owner_q) begin
							slot_valid_q  <= 1'b0;
							slot_ident_q  <= '0;
							slot_policy_q <= '0;
							retries_q     <= '0;
							r_armed_q     <= 1'b0;
							r_rem_q       <= '0;
							d_armed_q     <= 1'b0;
							d_rem_q       <= '0;
						end
						if (!fin_sv && !fin_da && wr_q != '0) begin
							d_armed_q <= 1'b1;
							d_rem_q   <= '0;
						end
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ov_q || evt.ready) begin
						ov_q                     <= 1'b1;
						evt_q.event_kind         <= res_kind_q;
						evt_q.event_requester    <= res_ev_q[39:32];
						evt_q.event_key          <= res_ev_q[31:16];
						evt_q.event_tag          <= res_ev_q[15:0];
						evt_q.dropped_or_pending <= res_count_q;
						evt_q.queued_total       <= qc32[6:0];
						evt_q.slot_busy          <= slot_valid_q;
						evt_q.slot_requester     <= slot_valid_q ? slot_ident_q[39:32] : 8'd0;
						evt_q.depth_warning      <= res_warn_q;
						st_q                     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_qc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qc_q) <= 32'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_retry_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		r_armed_q |-> slot_valid_q)
		else $error("retry timer armed with empty slot");

	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == ST_EXEC || st_q == ST_WALK))
		else $error("queue RAM written outside exec or walk");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (st_q == ST_EXEC))
		else $error("accepted request not executed");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Command queue testbench: a short table of directed requests, a fill past
// the depth, then random submits, ticks, reports, purges and counts, checked
// per field against a cycle-free predictor of the queue, slot and timers.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QDEPTH = 64;
	localparam int WDEPTH = 16;
	localparam int N_RANDOM = 1360;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sscq_cmd_if cmd ();
	sscq_evt_if evt ();

	single_slot_command_queue_retry_core #(
		.QUEUE_DEPTH(QDEPTH),
		.WARN_DEPTH (WDEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.evt   (evt)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [39:0] q_ident [QDEPTH];
	logic [35:0] q_policy [QDEPTH];
	int unsigned q_head, q_count;
	bit          s_valid;
	logic [39:0] s_ident;
	logic [35:0] s_policy;
	int unsigned s_retries;
	bit          disp_armed, retry_armed, warn_latched;
	int unsigned disp_rem, retry_rem;

	sscq_pkg::evt_t expected_events [$];
	int          errors = 0;
	int          events_seen = 0;
	bit          stim_done = 0;
	bit          long_stall = 0;
	int          kind_seen [8];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (event %0d)", what, got, want, events_seen);
	endtask

	function automatic bit timer_expires(ref bit armed, ref int unsigned rem);
		if (!armed) return 0;
		if (rem > 0) rem--;
		if (rem != 0) return 0;
		armed = 0;
		return 1;
	endfunction

	function automatic void free_slot();
		s_valid = 0; s_ident = '0; s_policy = '0; s_retries = 0;
		retry_armed = 0; retry_rem = 0;
	endfunction

	function automatic void post_next();
		if (!s_valid && !disp_armed && q_count > 0) begin
			disp_armed = 1;
			disp_rem = 0;
		end
	endfunction

	function automatic int unsigned drop_queued(input logic [7:0] req, input bit by_key,
			input logic [15:0] key);
		int unsigned w, dropped, s, d;
		w = 0;
		dropped = 0;
		for (int unsigned i = 0; i < q_count; i++) begin
			s = (q_head + i) % QDEPTH;
			if (q_ident[s][39:32] == req && (!by_key || q_ident[s][31:16] == key)) begin
				dropped++;
			end else begin
				d = (q_head + w) % QDEPTH;
				q_ident[d] = q_ident[s];
				q_policy[d] = q_policy[s];
				w++;
			end
		end
		q_count = w;
		return dropped;
	endfunction

	function automatic sscq_pkg::evt_t predict_event(input sscq_pkg::cmd_t c);
		sscq_pkg::evt_t e;
		logic [39:0] ev_id, id;
		int unsigned cnt, h, p;
		bit owner, warn;
		e = '0; ev_id = '0; cnt = 0; warn = 0;
		id = {c.requester_id, c.key_handle, c.command_tag};
		owner = s_valid && s_ident[39:32] == c.requester_id;
		case (c.opcode)
			sscq_pkg::OP_TICK: begin
				if (timer_expires(retry_armed, retry_rem) && s_valid) begin
					e.event_kind = sscq_pkg::EV_ISSUE;
					ev_id = s_ident;
				end
				if (timer_expires(disp_armed, disp_rem) && e.event_kind == sscq_pkg::EV_NONE &&
						!s_valid && q_count > 0) begin
					h = q_head;
					s_valid = 1;
					s_ident = q_ident[h];
					s_policy = q_policy[h];
					s_retries = 0;
					retry_armed = 0;
					retry_rem = 0;
					q_head = (q_head + 1) % QDEPTH;
					q_count--;
					e.event_kind = sscq_pkg::EV_ISSUE;
					ev_id = s_ident;
				end
			end
			sscq_pkg::OP_BACK, sscq_pkg::OP_FRONT: begin
				if (q_count >= QDEPTH) begin
					e.event_kind = sscq_pkg::EV_FULL;
					ev_id = id;
				end else begin
					if (c.opcode == sscq_pkg::OP_BACK) begin
						h = (q_head + q_count) % QDEPTH;
					end else begin
						q_head = (q_head + QDEPTH - 1) % QDEPTH;
						h = q_head;
					end
					q_ident[h] = id;
					q_policy[h] = {c.pace_ticks, c.retry_limit, c.retry_delay_ticks};
					q_count++;
					if (q_count >= WDEPTH) begin
						if (!warn_latched) begin
							warn_latched = 1;
							warn = 1;
						end
					end else if (q_count <= WDEPTH / 2) begin
						warn_latched = 0;
					end
					post_next();
				end
			end
			sscq_pkg::OP_SUCCESS: begin
				if (owner) begin
					p = 32'(s_policy[35:20]);
					free_slot();
					if (p > 0 && q_count > 0) begin
						disp_armed = 1;
						disp_rem = p;
					end else begin
						post_next();
					end
				end
			end
			sscq_pkg::OP_FAIL: begin
				if (owner) begin
					if (s_retries < 32'(s_policy[19:16])) begin
						s_retries++;
						retry_armed = 1;
						retry_rem = 32'(s_policy[15:0]);
					end else begin
						e.event_kind = sscq_pkg::EV_ABANDON;
						ev_id = s_ident;
						free_slot();
						disp_armed = 0;
						disp_rem = 0;
						post_next();
					end
				end
			end
			sscq_pkg::OP_FORGET: begin
				cnt = drop_queued(c.requester_id, 0, '0);
				if (owner) begin
					cnt++;
					free_slot();
					disp_armed = 0;
					disp_rem = 0;
				end
				post_next();
			end
			sscq_pkg::OP_DISCARD: begin
				if (q_count > 0) cnt = drop_queued(c.requester_id, 1, c.key_handle);
			end
			default: begin
				for (int unsigned i = 0; i < q_count; i++)
					if (q_ident[(q_head + i) % QDEPTH][39:32] == c.requester_id) cnt++;
				e.event_kind = sscq_pkg::EV_COUNT;
			end
		endcase
		e.event_requester = ev_id[39:32];
		e.event_key = ev_id[31:16];
		e.event_tag = ev_id[15:0];
		e.dropped_or_pending = cnt[6:0];
		e.queued_total = q_count[6:0];
		e.slot_busy = s_valid;
		e.slot_requester = s_valid ? s_ident[39:32] : 8'd0;
		e.depth_warning = warn;
		return e;
	endfunction

	function automatic sscq_pkg::cmd_t make_cmd(input logic [2:0] op, input logic [7:0] req,
			input logic [15:0] key, input logic [15:0] tag, input logic [15:0] pace,
			input logic [3:0] lim, input logic [15:0] dly);
		sscq_pkg::cmd_t c;
		c.opcode = op; c.requester_id = req; c.key_handle = key; c.command_tag = tag;
		c.pace_ticks = pace; c.retry_limit = lim; c.retry_delay_ticks = dly;
		return c;
	endfunction

	// small timers most of the time; the odd full-range value
	function automatic logic [15:0] rand_ticks();
		case ($urandom_range(0, 19))
			0: return 16'($urandom());
			1, 2, 3: return 16'd0;
			default: return 16'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic sscq_pkg::cmd_t rand_cmd(input bit noisy);
		sscq_pkg::cmd_t c;
		logic [2:0] op;
		logic [7:0] req;
		int r;
		r = $urandom_range(0, 99);
		if (noisy) op = 3'($urandom());
		else if (r < 30) op = sscq_pkg::OP_TICK;
		else if (r < 50) op = sscq_pkg::OP_BACK;
		else if (r < 56) op = sscq_pkg::OP_FRONT;
		else if (r < 70) op = sscq_pkg::OP_SUCCESS;
		else if (r < 84) op = sscq_pkg::OP_FAIL;
		else if (r < 88) op = sscq_pkg::OP_FORGET;
		else if (r < 93) op = sscq_pkg::OP_DISCARD;
		else op = sscq_pkg::OP_COUNT;
		// reports mostly from the slot holder so retries and pacing get exercised
		if ((op == sscq_pkg::OP_SUCCESS || op == sscq_pkg::OP_FAIL) && s_valid &&
				$urandom_range(0, 3) != 0)
			req = s_ident[39:32];
		else if ($urandom_range(0, 9) == 0) req = 8'($urandom());
		else req = 8'($urandom_range(0, 3));
		c = make_cmd(op, req, ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
			16'($urandom_range(0, 2)), 16'($urandom()), rand_ticks(),
			($urandom_range(0, 5) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2)),
			rand_ticks());
		return c;
	endfunction

	task automatic send_request(input sscq_pkg::cmd_t c, input bit has_want,
			input sscq_pkg::evt_t want);
		sscq_pkg::evt_t e;
		int gap;
		gap = stim_done ? 0 : $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// valid stays up across a zero gap
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data <= c;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		e = predict_event(c);
		if (has_want && e != want)
			report("directed row kind", 32'(e.event_kind), 32'(want.event_kind));
		expected_events.push_back(has_want ? want : e);
	endtask

	task automatic check_event(input sscq_pkg::evt_t got);
		sscq_pkg::evt_t want;
		events_seen++;
		if (expected_events.size() == 0) begin
			report("unexpected event kind", 32'(got.event_kind), 32'd0);
			return;
		end
		want = expected_events.pop_front();
		kind_seen[got.event_kind]++;
		if (got.event_kind != want.event_kind)
			report("event_kind", 32'(got.event_kind), 32'(want.event_kind));
		if (got.event_requester != want.event_requester)
			report("event_requester", 32'(got.event_requester), 32'(want.event_requester));
		if (got.event_key != want.event_key)
			report("event_key", 32'(got.event_key), 32'(want.event_key));
		if (got.event_tag != want.event_tag)
			report("event_tag", 32'(got.event_tag), 32'(want.event_tag));
		if (got.dropped_or_pending != want.dropped_or_pending)
			report("dropped_or_pending", 32'(got.dropped_or_pending),
				32'(want.dropped_or_pending));
		if (got.queued_total != want.queued_total)
			report("queued_total", 32'(got.queued_total), 32'(want.queued_total));
		if (got.slot_busy != want.slot_busy)
			report("slot_busy", 32'(got.slot_busy), 32'(want.slot_busy));
		if (got.slot_requester != want.slot_requester)
			report("slot_requester", 32'(got.slot_requester), 32'(want.slot_requester));
		if (got.depth_warning != want.depth_warning)
			report("depth_warning", 32'(got.depth_warning), 32'(want.depth_warning));
	endtask

	// receiver
	initial begin
		evt.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int wait_cycles;
			wait_cycles = long_stall ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 2) == 0) wait_cycles = 0;
			if (wait_cycles != 0 || long_stall) evt.ready <= 1'b0;
			repeat (wait_cycles) @(posedge clk);
			if (long_stall) begin
				repeat (400) @(posedge clk);
				long_stall = 0;
			end
			evt.ready <= 1'b1;
			@(posedge clk);
			while (!evt.valid) @(posedge clk);
			check_event(evt.data);
		end
	end

	typedef struct {
		sscq_pkg::cmd_t c;
		bit             has_want;
		sscq_pkg::evt_t want;
	} row_t;

	function automatic sscq_pkg::evt_t ev(input logic [2:0] k, input logic [39:0] id,
			input logic [6:0] cnt, input logic [6:0] qt, input bit busy,
			input logic [7:0] sreq, input bit w);
		return {k, id, cnt, qt, busy, sreq, w};
	endfunction

	// sender
	initial begin
		row_t rows [$];
		sscq_pkg::cmd_t c;
		int n;
		cmd.valid = 1'b0;
		cmd.data = '0;
		q_head = 0; q_count = 0; free_slot();
		disp_armed = 0; disp_rem = 0; warn_latched = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: values typed in where obvious, otherwise predicted
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h00, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			1, ev(sscq_pkg::EV_NONE, '0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_SUCCESS, 8'h00, 16'h0, 16'h0, 16'h0, 4'h0,
			16'h0), 1, ev(sscq_pkg::EV_NONE, '0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_DISCARD, 8'hff, 16'hffff, 16'h0, 16'h0, 4'h0,
			16'h0), 1, ev(sscq_pkg::EV_NONE, '0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_COUNT, 8'hff, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			1, ev(sscq_pkg::EV_COUNT, '0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_BACK, 8'hff, 16'hffff, 16'hffff, 16'h2, 4'hf,
			16'h0), 1, ev(sscq_pkg::EV_NONE, '0, 0, 1, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_FRONT, 8'h00, 16'h0, 16'h0, 16'hffff, 4'h0,
			16'hffff), 1, ev(sscq_pkg::EV_NONE, '0, 0, 2, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			1, ev(sscq_pkg::EV_ISSUE, '0, 0, 1, 1, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_FAIL, 8'h00, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			1, ev(sscq_pkg::EV_ABANDON, '0, 0, 1, 0, 0, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			1, ev(sscq_pkg::EV_ISSUE, 40'hff_ffff_ffff, 0, 0, 1, 8'hff, 0)});
		rows.push_back('{make_cmd(sscq_pkg::OP_FAIL, 8'hff, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_FAIL, 8'hff, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_BACK, 8'h12, 16'h5, 16'h7, 16'h0, 4'h1, 16'h1),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_FAIL, 8'h12, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_SUCCESS, 8'hff, 16'h0, 16'h0, 16'h0, 4'h0,
			16'h0), 0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_TICK, 8'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
			0, '0});
		rows.push_back('{make_cmd(sscq_pkg::OP_FORGET, 8'h12, 16'h0, 16'h0, 16'h0, 4'h0,
			16'h0), 0, '0});
		foreach (rows[i]) send_request(rows[i].c, rows[i].has_want, rows[i].want);

		// fill past the depth: warning, rejection when full, front submit when full
		for (int i = 0; i < QDEPTH + 2; i++)
			send_request(make_cmd(($urandom_range(0, 1) != 0) ? sscq_pkg::OP_BACK :
				sscq_pkg::OP_FRONT, 8'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
				16'($urandom()), 16'h0, 4'h1, 16'h1), 0, '0);
		for (int r = 0; r < 4; r++) begin
			send_request(make_cmd(sscq_pkg::OP_COUNT, 8'(r), 16'h0, 16'h0, 16'h0, 4'h0,
				16'h0), 0, '0);
			send_request(make_cmd(sscq_pkg::OP_DISCARD, 8'(r), 16'h1, 16'h0, 16'h0, 4'h0,
				16'h0), 0, '0);
		end

		// one long receiver hold-off while requests keep coming
		long_stall = 1;
		n = 0;
		while (n < N_RANDOM) begin
			// bursts that refill the queue now and then to swing the warning
			if ($urandom_range(0, 199) == 0) begin
				repeat ($urandom_range(10, 40)) begin
					send_request(make_cmd(sscq_pkg::OP_BACK, 8'($urandom_range(0, 3)),
						16'($urandom()), 16'($urandom()), rand_ticks(), 4'($urandom()),
						rand_ticks()), 0, '0);
					n++;
				end
			end
			c = rand_cmd($urandom_range(0, 9) == 0);
			send_request(c, 0, '0);
			n++;
		end
		cmd.valid <= 1'b0;
		stim_done = 1;
	end

	// completion and watchdog
	initial begin
		wait (stim_done);
		while (expected_events.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d events: %0d issue, %0d abandoned, %0d count, %0d rejected",
			events_seen, kind_seen[sscq_pkg::EV_ISSUE], kind_seen[sscq_pkg::EV_ABANDON],
			kind_seen[sscq_pkg::EV_COUNT], kind_seen[sscq_pkg::EV_FULL]);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timed out with %0d events outstanding", expected_events.size());
		$display("FAILURE");
		$finish;
	end

endmodule
